/* hw/rtl/vt4_pkg.sv */
// shared types, widths and constants of the 4x4 vertex transform
package vt4_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;
  localparam int LANES         = 4;
  localparam int NUM_CELLS     = LANES * LANES;
  localparam int NUM_REGS      = NUM_CELLS / 2;
  localparam int REG_W         = 2 * DATA_W;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int CFG_IDX_W     = REG_IDX_W + 1;

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SHP_W  = PROD_W - FRACTION_BITS;
  localparam int HALF_W = SHP_W + 1;
  localparam int SUM_W  = SHP_W + 2;

  typedef logic [DATA_W-1:0]        word_t;
  typedef logic [REG_W-1:0]         reg_word_t;
  typedef logic signed [SHP_W-1:0]  prod_t;
  typedef logic signed [HALF_W-1:0] half_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam reg_word_t ONE_LO = reg_word_t'(1) << FRACTION_BITS;
  localparam reg_word_t ONE_HI = ONE_LO << DATA_W;

  // identity matrix, two cells per register
  localparam reg_word_t CFG_RESET [NUM_REGS] = '{
    ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
  };

  localparam sum_t SAT_HI = sum_t'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
  localparam sum_t SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_x;
    logic signed [DATA_W-1:0] in_y;
    logic signed [DATA_W-1:0] in_z;
    logic signed [DATA_W-1:0] in_w;
  } vec_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     clipped;
  } vec_out_t;

  typedef struct packed {
    logic ld_prod;
    logic ld_half;
  } lane_ctl_t;

endpackage

/* hw/rtl/vt4_cfg.sv */
// matrix register file, two q16.16 cells per 64-bit register
module vt4_cfg import vt4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  output word_t                cells [NUM_CELLS]
);

  reg_word_t cfg_r [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // even cell in the low half, odd cell in the high half
  always_comb begin
    for (int k = 0; k < NUM_CELLS; k++) begin
      cells[k] = cfg_r[k / 2][(k % 2) * DATA_W +: DATA_W];
    end
  end

endmodule

/* hw/rtl/vt4_lane.sv */
// one matrix row: four products registered, then two pair sums registered
module vt4_lane import vt4_pkg::*; (
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  vec_in_t   vec,
  input  word_t     coef [LANES],
  output half_t     half_sum [2]
);

  logic signed [WORD_BITS-1:0] op_a [LANES];
  logic signed [WORD_BITS-1:0] op_b [LANES];
  logic signed [PROD_W-1:0]    full [LANES];
  prod_t                       prod_nxt [LANES];
  prod_t                       prod_r [LANES];
  half_t                       half_r [2];

  always_comb begin
    op_b[0] = vec.in_x[WORD_BITS-1:0];
    op_b[1] = vec.in_y[WORD_BITS-1:0];
    op_b[2] = vec.in_z[WORD_BITS-1:0];
    op_b[3] = vec.in_w[WORD_BITS-1:0];
    for (int c = 0; c < LANES; c++) begin
      op_a[c] = coef[c][WORD_BITS-1:0];
      full[c] = op_a[c] * op_b[c];
      // arithmetic shift rounds toward minus infinity
      prod_nxt[c] = prod_t'(full[c] >>> FRACTION_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.ld_half) begin
      half_r[0] <= half_t'(prod_r[0]) + half_t'(prod_r[1]);
      half_r[1] <= half_t'(prod_r[2]) + half_t'(prod_r[3]);
    end
  end

  assign half_sum = half_r;

endmodule

/* hw/rtl/vt4_merge.sv */
// final row sums, saturation, clip flag and the output register
module vt4_merge import vt4_pkg::*; (
  input  logic     clk,
  input  logic     ld,
  input  half_t    lane_half [LANES][2],
  output vec_out_t out_data
);

  sum_t                     sum [LANES];
  sum_t                     sat [LANES];
  logic [LANES-1:0]         hit;
  logic signed [DATA_W-1:0] res [LANES];
  vec_out_t                 out_nxt;
  vec_out_t                 out_r;

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      sum[r] = sum_t'(lane_half[r][0]) + sum_t'(lane_half[r][1]);
      hit[r] = 1'b1;
      if (sum[r] > SAT_HI) begin
        sat[r] = SAT_HI;
      end else if (sum[r] < SAT_LO) begin
        sat[r] = SAT_LO;
      end else begin
        sat[r] = sum[r];
        hit[r] = 1'b0;
      end
      res[r] = DATA_W'($signed(sat[r][WORD_BITS-1:0]));
    end
    out_nxt.out_x   = res[0];
    out_nxt.out_y   = res[1];
    out_nxt.out_z   = res[2];
    out_nxt.out_w   = res[3];
    out_nxt.clipped = |hit;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

/* hw/rtl/vertex_transform_4x4.sv */
// top level of the 4x4 matrix times vector transform
//
// in channel: one homogeneous vector (x, y, z, w) per request, signed
// q16.16, taken at an edge with in_valid high and in_stall low.
// out channel: the four transformed components plus a clipped flag,
// handed over at an edge with out_valid high and out_stall low.
// cfg channel: eight 64-bit matrix registers, two column-major cells each;
// cfg_ready is always high, indexes of eight and above are dropped.
// a request passes through the product register, the pair sum register and
// the output register in that order, one row per lane.
// throughput is one vector per cycle while out_stall is low, with the four
// lanes of four multipliers each; under out_stall, requests keep entering
// while empty stages remain behind a stalled result.
// reset loads the identity matrix and empties the pipeline.
// while out_stall is high the shown result holds and the pipe fills up,
// after which in_stall rises.
module vertex_transform_4x4 import vt4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vec_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vec_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  word_t     cells [NUM_CELLS];
  word_t     lane_coef [LANES][LANES];
  half_t     lane_half [LANES][2];
  lane_ctl_t ctl;

  logic vld_a_r, vld_a_nxt;
  logic vld_b_r, vld_b_nxt;
  logic out_valid_r, out_valid_nxt;
  logic en_a, en_b, en_out;

  vt4_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells)
  );

  // lane r sees row r: cell c*4+r for column c
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      for (int c = 0; c < LANES; c++) begin
        lane_coef[r][c] = cells[c * LANES + r];
      end
    end
  end

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en_out        = !out_valid_r || !out_stall;
    en_b          = !vld_b_r || en_out;
    en_a          = !vld_a_r || en_b;
    ctl.ld_prod   = en_a;
    ctl.ld_half   = en_b;
    vld_a_nxt     = en_a ? in_valid : vld_a_r;
    vld_b_nxt     = en_b ? vld_a_r : vld_b_r;
    out_valid_nxt = en_out ? vld_b_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r     <= 1'b0;
      vld_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_a_r     <= vld_a_nxt;
      vld_b_r     <= vld_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    vt4_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .vec      (in_data),
      .coef     (lane_coef[r]),
      .half_sum (lane_half[r])
    );
  end

  vt4_merge u_merge (
    .clk       (clk),
    .ld        (en_out),
    .lane_half (lane_half),
    .out_data  (out_data)
  );

  assign in_stall  = !en_a;
  assign out_valid = out_valid_r;

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_a_r && vld_b_r && out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while every stage is held");

  a_stage_b_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && vld_b_r) |=> out_valid_r)
    else $error("pair sums lost on the way to the output");

  a_result_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid_r) && $past(rst_n)) |-> $past(!out_stall))
    else $error("result withdrawn while stalled");

  a_stage_a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    (en_b && vld_a_r) |=> vld_b_r)
    else $error("products lost on the way to the pair sums");

endmodule

/* bench/tb_top.sv */
// testbench for the 4x4 vertex transform: directed table, random vertices and matrices, scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vt4_pkg::*;

  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     LONG_HOLD      = 40;
  localparam int     DRAIN_CYCLES   = 4;
  localparam int     ITEMS_PER_SET  = 200;
  localparam longint SAT_MAX        = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam longint SAT_MIN        = -SAT_MAX - 64'sd1;

  localparam word_t W_MAX  = 32'h7fff_ffff;
  localparam word_t W_MIN  = 32'h8000_0000;
  localparam word_t W_ONE  = 32'h0001_0000;
  localparam word_t W_NEG1 = 32'hffff_ffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRIES_0_1   = 0,
    REG_ENTRIES_2_3   = 1,
    REG_ENTRIES_4_5   = 2,
    REG_ENTRIES_6_7   = 3,
    REG_ENTRIES_8_9   = 4,
    REG_ENTRIES_10_11 = 5,
    REG_ENTRIES_12_13 = 6,
    REG_ENTRIES_14_15 = 7,
    REG_UNUSED_9      = 9,
    REG_UNUSED_15     = 15
  } cfg_reg_e;

  typedef enum int {STYLE_AFFINE, STYLE_RANDOM, STYLE_EXTREME} matrix_style_e;

  typedef struct {
    bit        is_cfg;
    cfg_reg_e  reg_idx;
    reg_word_t reg_val;
    vec_in_t   vec;
    bit        fixed;
    vec_out_t  want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vec_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vec_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  // hand-typed expectation riding along with each request
  bit        in_fixed = 1'b0;
  vec_out_t  in_fixed_val = '0;

  reg_word_t matrix_regs [NUM_REGS] = CFG_RESET;
  vec_out_t  transformed_q [$];
  int        vertices_in = 0;
  int        vertices_out = 0;
  int        err_count = 0;
  int        stuck_cycles = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_served = 0;
  int        hold_left = 0;
  step_t     directed_steps [$];

  vertex_transform_4x4 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic vec_out_t transform_vertex(input vec_in_t v);
    longint                   comp [LANES];
    longint                   acc;
    logic signed [DATA_W-1:0] coef;
    logic [DATA_W-1:0]        lane [LANES];
    int                       k;
    bit                       sat;
    vec_out_t                 r;
    comp[0] = longint'(v.in_x);
    comp[1] = longint'(v.in_y);
    comp[2] = longint'(v.in_z);
    comp[3] = longint'(v.in_w);
    sat = 1'b0;
    for (int row = 0; row < LANES; row++) begin
      acc = 0;
      for (int col = 0; col < LANES; col++) begin
        // column-major: cell col*4+row, two cells per register
        k = col * LANES + row;
        coef = matrix_regs[k / 2][(k % 2) * DATA_W +: DATA_W];
        acc += (longint'(coef) * comp[col]) >>> FRACTION_BITS;
      end
      if (acc > SAT_MAX) begin
        acc = SAT_MAX;
        sat = 1'b1;
      end else if (acc < SAT_MIN) begin
        acc = SAT_MIN;
        sat = 1'b1;
      end
      lane[row] = acc[DATA_W-1:0];
    end
    r.out_x   = lane[0];
    r.out_y   = lane[1];
    r.out_z   = lane[2];
    r.out_w   = lane[3];
    r.clipped = sat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // scoreboard, shadow config and watchdog
  always @(posedge clk) begin
    vec_out_t want;
    bit       moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        if (cfg_index < CFG_IDX_W'(NUM_REGS))
          matrix_regs[cfg_index[REG_IDX_W-1:0]] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        vertices_out <= vertices_out + 1;
        if (transformed_q.size() == 0) begin
          report_mismatch("result with no request pending", out_data.out_x, '0);
        end else begin
          want = transformed_q.pop_front();
          if (out_data.out_x !== want.out_x) report_mismatch("out_x", out_data.out_x, want.out_x);
          if (out_data.out_y !== want.out_y) report_mismatch("out_y", out_data.out_y, want.out_y);
          if (out_data.out_z !== want.out_z) report_mismatch("out_z", out_data.out_z, want.out_z);
          if (out_data.out_w !== want.out_w) report_mismatch("out_w", out_data.out_w, want.out_w);
          if (out_data.clipped !== want.clipped)
            report_mismatch("clipped", DATA_W'(out_data.clipped), DATA_W'(want.clipped));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        vertices_in <= vertices_in + 1;
        transformed_q.push_back(in_fixed ? in_fixed_val : transform_vertex(in_data));
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // result side: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_served) begin
        out_stall <= 1'b1;
        hold_left++;
        if (hold_left == LONG_HOLD) begin
          hold_left = 0;
          hold_served++;
        end
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic word_t pick_extreme();
    case ($urandom_range(6))
      0: return W_MAX;
      1: return W_MIN;
      2: return '0;
      3: return W_ONE;
      4: return -W_ONE;
      5: return word_t'(1);
      default: return W_NEG1;
    endcase
  endfunction

  // signed value spread evenly from -2^(bits-1) to 2^(bits-1)-1
  function automatic word_t rand_small(input int bits);
    return word_t'($urandom_range(0, (1 << bits) - 1)) - word_t'(1 << (bits - 1));
  endfunction

  function automatic vec_in_t random_vertex();
    int      pick;
    vec_in_t v;
    pick = $urandom_range(99);
    if (pick < 55) begin
      v.in_x = rand_small(25);
      v.in_y = rand_small(25);
      v.in_z = rand_small(25);
      v.in_w = W_ONE;
    end else if (pick < 75) begin
      v.in_x = $urandom;
      v.in_y = $urandom;
      v.in_z = $urandom;
      v.in_w = $urandom;
    end else if (pick < 90) begin
      v.in_x = rand_small(20);
      v.in_y = rand_small(20);
      v.in_z = rand_small(20);
      v.in_w = rand_small(20);
    end else begin
      v.in_x = pick_extreme();
      v.in_y = pick_extreme();
      v.in_z = pick_extreme();
      v.in_w = pick_extreme();
    end
    return v;
  endfunction

  function automatic step_t cfg_row(input cfg_reg_e idx, input reg_word_t val);
    step_t s;
    s = '{reg_idx: REG_ENTRIES_0_1, default: '0};
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t vec_row(input word_t x, input word_t y, input word_t z,
                                    input word_t w);
    step_t s;
    s = '{reg_idx: REG_ENTRIES_0_1, default: '0};
    s.vec = {x, y, z, w};
    return s;
  endfunction

  function automatic step_t fix_row(input word_t x, input word_t y, input word_t z,
                                    input word_t w, input word_t ox, input word_t oy,
                                    input word_t oz, input word_t ow, input logic clip);
    step_t s;
    s = vec_row(x, y, z, w);
    s.fixed = 1'b1;
    s.want  = {ox, oy, oz, ow, clip};
    return s;
  endfunction

  task automatic send_vertex(input vec_in_t v, input bit fixed, input vec_out_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= v;
    in_fixed     <= fixed;
    in_fixed_val <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every result is back and the pipe is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertices_in != vertices_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input reg_word_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_matrix(input matrix_style_e style);
    word_t cells [NUM_CELLS];
    for (int c = 0; c < LANES; c++) begin
      for (int r = 0; r < LANES; r++) begin
        case (style)
          STYLE_AFFINE: begin
            if (r == LANES - 1) cells[c * LANES + r] = (c == LANES - 1) ? W_ONE : '0;
            else if (c == LANES - 1) cells[c * LANES + r] = rand_small(25);
            else cells[c * LANES + r] = rand_small(19);
          end
          STYLE_RANDOM: cells[c * LANES + r] = $urandom;
          default: cells[c * LANES + r] = pick_extreme();
        endcase
      end
    end
    wait_drained();
    // out-of-range index must leave the matrix alone
    write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(NUM_REGS - 1)), {$urandom, $urandom});
    for (int k = 0; k < NUM_REGS; k++)
      write_reg(cfg_reg_e'(k), {cells[2 * k + 1], cells[2 * k]});
  endtask

  initial begin
    int idle_sched [4];
    int stall_sched [4];
    idle_sched  = '{0, 45, 0, 24};
    stall_sched = '{0, 0, 45, 24};
    directed_steps = '{
      fix_row('0, '0, '0, '0, '0, '0, '0, '0, 1'b0),
      fix_row(W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 1'b0),
      fix_row(W_MAX, W_MIN, W_NEG1, 1, W_MAX, W_MIN, W_NEG1, 1, 1'b0),
      fix_row(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0),
      fix_row(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0),
      cfg_row(REG_UNUSED_9, '1),
      cfg_row(REG_UNUSED_15, '1),
      fix_row(32'h1234_5678, -5, 3, W_ONE, 32'h1234_5678, -5, 3, W_ONE, 1'b0),
      cfg_row(REG_ENTRIES_0_1, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_2_3, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_4_5, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_6_7, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_8_9, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_10_11, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_12_13, {W_MAX, W_MAX}),
      cfg_row(REG_ENTRIES_14_15, {W_MAX, W_MAX}),
      // saturation both ways
      fix_row(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1),
      fix_row(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1),
      fix_row('0, '0, '0, '0, '0, '0, '0, '0, 1'b0),
      cfg_row(REG_ENTRIES_0_1, {W_MIN, W_MIN}),
      cfg_row(REG_ENTRIES_2_3, {W_MIN, W_MIN}),
      fix_row(W_MAX, '0, '0, '0, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1),
      fix_row(W_MIN, '0, '0, '0, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1),
      // negative products round toward minus infinity
      cfg_row(REG_ENTRIES_0_1, '1),
      cfg_row(REG_ENTRIES_2_3, '1),
      fix_row(1, '0, '0, '0, W_NEG1, W_NEG1, W_NEG1, W_NEG1, 1'b0),
      fix_row(W_NEG1, '0, '0, '0, '0, '0, '0, '0, 1'b0),
      vec_row(32'h0001_8000, 32'hfffd_c000, 7, W_ONE),
      vec_row(32'h7ffe_0001, W_MIN, 32'h0000_0123, 32'hdead_beef)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_drained();
        write_reg(directed_steps[i].reg_idx, directed_steps[i].reg_val);
      end else begin
        send_vertex(directed_steps[i].vec, directed_steps[i].fixed, directed_steps[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_sched[p];
      stall_pct <= stall_sched[p];
      for (int h = 0; h < 2; h++) begin
        load_matrix(matrix_style_e'((2 * p + h) % 3));
        if (p == 0 && h == 0) begin
          // hold the result side off while requests keep coming, so the pipe backs up
          hold_req <= hold_req + 1;
          repeat (24) send_vertex(random_vertex(), 1'b0, '0);
        end
        repeat (ITEMS_PER_SET) send_vertex(random_vertex(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/vt4_pkg.sv
hw/rtl/vt4_cfg.sv
hw/rtl/vt4_lane.sv
hw/rtl/vt4_merge.sv
hw/rtl/vertex_transform_4x4.sv
bench/tb_top.sv
